### rtl/pncd_pkg.sv
// Types and constants shared by the PN correlation bit detector modules.
package pncd_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int PN_BITS        = 8;
    localparam int PN_INDEX_BITS  = 6;
    localparam int THR_BITS       = 16;
    localparam int SEARCH_BITS    = 6;
    localparam int HOLD_BITS      = 8;
    localparam int ERR_BITS       = 16;
    localparam int CFG_ADDR_BITS  = 4;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_ADDR_BITS-1:0] REG_LOW_THRESHOLD  = 4'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HIGH_THRESHOLD = 4'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SEARCH_BACK    = 4'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HOLD_COUNT     = 4'd3;

    localparam logic [THR_BITS-1:0]    LOW_THRESHOLD_RST  = 16'd6554;
    localparam logic [THR_BITS-1:0]    HIGH_THRESHOLD_RST = 16'd9830;
    localparam logic [SEARCH_BITS-1:0] SEARCH_BACK_RST    = 6'd10;
    localparam logic [HOLD_BITS-1:0]   HOLD_COUNT_RST     = 8'd100;
    localparam logic [1:0]             LAST_BIT_NONE      = 2'd2;
    localparam logic [ERR_BITS-1:0]    ERR_MAX            = 16'hFFFF;

    typedef struct packed {
        logic                          mode;
        logic signed [SAMPLE_BITS-1:0] sample_re;
        logic signed [SAMPLE_BITS-1:0] sample_im;
        logic [PN_INDEX_BITS-1:0]      pn_index;
        logic signed [PN_BITS-1:0]     pn_re;
        logic signed [PN_BITS-1:0]     pn_im;
    } pncd_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_re;
        logic signed [SAMPLE_BITS-1:0] out_im;
        logic                          pn_found;
        logic                          bit_value;
        logic [ERR_BITS-1:0]           repeat_errors;
    } pncd_out_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } smp_t;

    typedef struct packed {
        logic signed [PN_BITS-1:0] re;
        logic signed [PN_BITS-1:0] im;
    } pnv_t;

    typedef struct packed {
        logic                     rotate;
        logic                     insert;
        logic                     pn_write;
        logic [PN_INDEX_BITS-1:0] pn_index;
    } cell_ctl_t;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_ACC      = 8'b0000_0010,
        ST_POST1    = 8'b0000_0100,
        ST_POST2    = 8'b0000_1000,
        ST_MUL_GO   = 8'b0001_0000,
        ST_MUL_WAIT = 8'b0010_0000,
        ST_DECIDE   = 8'b0100_0000,
        ST_FINISH   = 8'b1000_0000
    } state_t;

endpackage

### rtl/pn_correlation_bit_detector.sv
// Top level of the PN correlation bit detector: cell ring, accumulator, sequencer.
//
// Passes each sample through with a peak tag. A mode-1 transfer writes one PN
// entry and gives no result. A sample inside the skip period goes straight to
// the result stage without a check. For a checked sample the ring of cells
// rotates once past the single accumulator, then one shift-add multiplier works
// out the two squared numerator parts and the two threshold products, one bit
// per cycle. One sample is worked on at a time; the next is taken once its
// result sits in the output register.
module pn_correlation_bit_detector import pncd_pkg::*; #(
    parameter int WINDOW_LEN = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  pncd_in_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output pncd_out_t                m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int L    = $clog2(WINDOW_LEN);
    localparam int SB   = SAMPLE_BITS;
    localparam int PB   = PN_BITS;
    localparam int MW   = SB + PB + 1 + L;
    localparam int SRW  = SB + L;
    localparam int PRW  = PB + L;
    localparam int QW   = 2 * SB + L;
    localparam int P1W  = PRW + SRW;
    localparam int AW   = SB + PB + 2 * L + 2;
    localparam int SQW  = 2 * SRW;
    localparam int DW   = 2 * SB + 2 * L + 1;
    localparam int T2W  = 2 * THR_BITS;
    localparam int KW   = T2W + 2 * L;
    localparam int XW   = (AW > KW) ? AW : KW;
    localparam int YW   = (AW > DW) ? AW : DW;
    localparam int PW   = XW + YW;
    localparam int A2W  = 2 * AW + 1;
    localparam int CW   = (A2W + 32 > PW) ? A2W + 32 : PW;
    localparam int NSQ  = WINDOW_LEN * WINDOW_LEN;

    localparam logic [1:0] OP_AR2 = 2'd0;
    localparam logic [1:0] OP_AI2 = 2'd1;
    localparam logic [1:0] OP_KL  = 2'd2;
    localparam logic [1:0] OP_KH  = 2'd3;

    // cell ring
    cell_ctl_t ctl;
    smp_t      smp_q [WINDOW_LEN];
    pnv_t      pn_q  [WINDOW_LEN];
    smp_t      nb_smp [WINDOW_LEN];
    pnv_t      nb_pn  [WINDOW_LEN];
    pnv_t      wr_pn;
    smp_t      new_smp;

    state_t state_reg, state_next;

    logic [THR_BITS-1:0]    lt_reg, lt_next, ht_reg, ht_next;
    logic [SEARCH_BITS-1:0] sb_reg, sb_next;
    logic [HOLD_BITS-1:0]   hold_reg, hold_next;
    logic [L-1:0]           skip_reg, skip_next;
    logic [HOLD_BITS-1:0]   conf_reg, conf_next;
    logic [1:0]             last_reg, last_next;
    logic [ERR_BITS-1:0]    err_reg, err_next;
    logic [L-1:0]           cnt_reg, cnt_next;
    logic [1:0]             op_reg, op_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   found_reg, found_next;
    logic                   bit_reg, bit_next;

    smp_t                   hold_smp_reg, hold_smp_next;
    pncd_out_t              out_reg, out_next;
    logic signed [MW-1:0]   mr_reg, mr_next, mi_reg, mi_next;
    logic signed [SRW-1:0]  sr_reg, sr_next, si_reg, si_next;
    logic signed [PRW-1:0]  pr_reg, pr_next;
    logic [QW-1:0]          q_reg, q_next;
    logic signed [P1W-1:0]  p1_reg, p1_next, p2_reg, p2_next;
    logic [SQW-1:0]         sr2_reg, sr2_next, si2_reg, si2_next;
    logic [T2W-1:0]         lt2_reg, lt2_next, ht2_reg, ht2_next;
    logic signed [AW-1:0]   ar_reg, ar_next, ai_reg, ai_next;
    logic [DW-1:0]          d_reg, d_next;
    logic [KW-1:0]          kl_reg, kl_next, kh_reg, kh_next;
    logic [2*AW-1:0]        ar2_reg, ar2_next, ai2_reg, ai2_next;
    logic [PW-1:0]          pl_reg, pl_next, ph_reg, ph_next;

    logic s_fire, fin_fire, cfg_fire;
    logic signed [SB+PB-1:0] p_rr, p_ii, p_ri, p_ir;
    logic [2*SB-1:0]         q_r, q_i;
    logic [AW-1:0]           ar_mag, ai_mag;
    logic                    mul_start, mul_done;
    logic [XW-1:0]           mul_x;
    logic [YW-1:0]           mul_y;
    logic [PW-1:0]           mul_prod;
    logic [A2W-1:0]          a2;
    logic [CW-1:0]           a2_sh;
    logic                    dec_found, dec_strong, dec_pos;
    logic [L-1:0]            skip_load;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign fin_fire  = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    assign ctl.rotate   = (state_reg == ST_ACC);
    assign ctl.insert   = fin_fire;
    assign ctl.pn_write = s_fire && s_data.mode;
    assign ctl.pn_index = s_data.pn_index;
    assign wr_pn.re     = s_data.pn_re;
    assign wr_pn.im     = s_data.pn_im;
    assign new_smp      = hold_smp_reg;

    for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
        if (k == WINDOW_LEN - 1) begin : g_last
            assign nb_smp[k] = ctl.insert ? new_smp : smp_q[0];
            assign nb_pn[k]  = pn_q[0];
        end else begin : g_mid
            assign nb_smp[k] = smp_q[k+1];
            assign nb_pn[k]  = pn_q[k+1];
        end
        pncd_cell #(.CELL_INDEX(k)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .nb_smp  (nb_smp[k]),
            .nb_pn   (nb_pn[k]),
            .wr_pn   (wr_pn),
            .smp_q   (smp_q[k]),
            .pn_q    (pn_q[k])
        );
    end

    // accumulator terms from the head cell
    assign p_rr = (SB+PB)'(smp_q[0].re) * (SB+PB)'(pn_q[0].re);
    assign p_ii = (SB+PB)'(smp_q[0].im) * (SB+PB)'(pn_q[0].im);
    assign p_ri = (SB+PB)'(smp_q[0].re) * (SB+PB)'(pn_q[0].im);
    assign p_ir = (SB+PB)'(smp_q[0].im) * (SB+PB)'(pn_q[0].re);
    assign q_r  = (2*SB)'(smp_q[0].re) * (2*SB)'(smp_q[0].re);
    assign q_i  = (2*SB)'(smp_q[0].im) * (2*SB)'(smp_q[0].im);

    assign ar_mag = ar_reg[AW-1] ? AW'(-ar_reg) : AW'(ar_reg);
    assign ai_mag = ai_reg[AW-1] ? AW'(-ai_reg) : AW'(ai_reg);

    always_comb begin
        unique case (op_reg)
            OP_AR2: begin
                mul_x = XW'(ar_mag);
                mul_y = YW'(ar_mag);
            end
            OP_AI2: begin
                mul_x = XW'(ai_mag);
                mul_y = YW'(ai_mag);
            end
            OP_KL: begin
                mul_x = XW'(kl_reg);
                mul_y = YW'(d_reg);
            end
            default: begin
                mul_x = XW'(kh_reg);
                mul_y = YW'(d_reg);
            end
        endcase
    end

    assign mul_start = (state_reg == ST_MUL_GO);

    pncd_smul #(.XW(XW), .YW(YW)) u_smul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    assign a2    = A2W'(ar2_reg) + A2W'(ai2_reg);
    assign a2_sh = CW'(a2) << 32;

    always_comb begin
        if (d_reg == '0) begin
            dec_found  = (lt_reg == '0);
            dec_strong = (ht_reg == '0);
            dec_pos    = 1'b1;
        end else begin
            dec_found  = a2_sh > CW'(pl_reg);
            dec_strong = a2_sh > CW'(ph_reg);
            dec_pos    = !ar_reg[AW-1] && (ar_reg != '0);
        end
        if (32'(WINDOW_LEN) > 32'(sb_reg) + 32'd1) begin
            skip_load = L'(32'(WINDOW_LEN) - 32'(sb_reg) - 32'd1);
        end else begin
            skip_load = '0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        lt_next       = lt_reg;
        ht_next       = ht_reg;
        sb_next       = sb_reg;
        hold_next     = hold_reg;
        skip_next     = skip_reg;
        conf_next     = conf_reg;
        last_next     = last_reg;
        err_next      = err_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        m_valid_next  = m_valid_reg;
        found_next    = found_reg;
        bit_next      = bit_reg;
        hold_smp_next = hold_smp_reg;
        out_next      = out_reg;
        mr_next       = mr_reg;
        mi_next       = mi_reg;
        sr_next       = sr_reg;
        si_next       = si_reg;
        pr_next       = pr_reg;
        q_next        = q_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        sr2_next      = sr2_reg;
        si2_next      = si2_reg;
        lt2_next      = lt2_reg;
        ht2_next      = ht2_reg;
        ar_next       = ar_reg;
        ai_next       = ai_reg;
        d_next        = d_reg;
        kl_next       = kl_reg;
        kh_next       = kh_reg;
        ar2_next      = ar2_reg;
        ai2_next      = ai2_reg;
        pl_next       = pl_reg;
        ph_next       = ph_reg;

        if (cfg_fire) begin
            priority if (cfg_addr == REG_LOW_THRESHOLD) begin
                lt_next = cfg_data[THR_BITS-1:0];
            end else if (cfg_addr == REG_HIGH_THRESHOLD) begin
                ht_next = cfg_data[THR_BITS-1:0];
            end else if (cfg_addr == REG_SEARCH_BACK) begin
                sb_next = cfg_data[SEARCH_BITS-1:0];
            end else if (cfg_addr == REG_HOLD_COUNT) begin
                hold_next = cfg_data[HOLD_BITS-1:0];
            end else begin
                lt_next = lt_reg;
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && !s_data.mode) begin
                    hold_smp_next.re = s_data.sample_re;
                    hold_smp_next.im = s_data.sample_im;
                    found_next       = 1'b0;
                    bit_next         = 1'b0;
                    if (skip_reg != '0) begin
                        skip_next  = skip_reg - 1'b1;
                        state_next = ST_FINISH;
                    end else begin
                        if (conf_reg != '0) begin
                            conf_next = conf_reg - 1'b1;
                        end
                        mr_next    = '0;
                        mi_next    = '0;
                        sr_next    = '0;
                        si_next    = '0;
                        pr_next    = '0;
                        q_next     = '0;
                        cnt_next   = '0;
                        state_next = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                mr_next  = mr_reg + MW'(p_rr) - MW'(p_ii);
                mi_next  = mi_reg + MW'(p_ri) + MW'(p_ir);
                sr_next  = sr_reg + SRW'(smp_q[0].re);
                si_next  = si_reg + SRW'(smp_q[0].im);
                pr_next  = pr_reg + PRW'(pn_q[0].re);
                q_next   = q_reg + QW'(q_r) + QW'(q_i);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == L'(WINDOW_LEN - 1)) begin
                    state_next = ST_POST1;
                end
            end
            ST_POST1: begin
                p1_next    = P1W'(pr_reg) * P1W'(sr_reg);
                p2_next    = P1W'(pr_reg) * P1W'(si_reg);
                sr2_next   = SQW'(sr_reg) * SQW'(sr_reg);
                si2_next   = SQW'(si_reg) * SQW'(si_reg);
                lt2_next   = T2W'(lt_reg) * T2W'(lt_reg);
                ht2_next   = T2W'(ht_reg) * T2W'(ht_reg);
                state_next = ST_POST2;
            end
            ST_POST2: begin
                ar_next    = AW'(mr_reg) * AW'(WINDOW_LEN) - AW'(p1_reg);
                ai_next    = AW'(mi_reg) * AW'(WINDOW_LEN) - AW'(p2_reg);
                d_next     = DW'(q_reg) * DW'(WINDOW_LEN) - DW'(sr2_reg) - DW'(si2_reg);
                kl_next    = KW'(lt2_reg) * KW'(NSQ);
                kh_next    = KW'(ht2_reg) * KW'(NSQ);
                op_next    = OP_AR2;
                state_next = ST_MUL_GO;
            end
            ST_MUL_GO: begin
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    unique case (op_reg)
                        OP_AR2:  ar2_next = mul_prod[2*AW-1:0];
                        OP_AI2:  ai2_next = mul_prod[2*AW-1:0];
                        OP_KL:   pl_next  = mul_prod;
                        default: ph_next  = mul_prod;
                    endcase
                    if (op_reg == OP_KH) begin
                        state_next = ST_DECIDE;
                    end else begin
                        op_next    = op_reg + 1'b1;
                        state_next = ST_MUL_GO;
                    end
                end
            end
            ST_DECIDE: begin
                found_next = dec_found;
                bit_next   = dec_found && dec_pos;
                if (dec_found) begin
                    if (last_reg == {1'b0, dec_pos} && err_reg != ERR_MAX) begin
                        err_next = err_reg + 1'b1;
                    end
                    last_next = {1'b0, dec_pos};
                    if (dec_strong || conf_reg != '0) begin
                        conf_next = hold_reg;
                        skip_next = skip_load;
                    end
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (fin_fire) begin
                    out_next.out_re        = hold_smp_reg.re;
                    out_next.out_im        = hold_smp_reg.im;
                    out_next.pn_found      = found_reg;
                    out_next.bit_value     = bit_reg;
                    out_next.repeat_errors = err_reg;
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lt_reg      <= LOW_THRESHOLD_RST;
            ht_reg      <= HIGH_THRESHOLD_RST;
            sb_reg      <= SEARCH_BACK_RST;
            hold_reg    <= HOLD_COUNT_RST;
            skip_reg    <= '0;
            conf_reg    <= '0;
            last_reg    <= LAST_BIT_NONE;
            err_reg     <= '0;
            cnt_reg     <= '0;
            op_reg      <= '0;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            bit_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lt_reg      <= lt_next;
            ht_reg      <= ht_next;
            sb_reg      <= sb_next;
            hold_reg    <= hold_next;
            skip_reg    <= skip_next;
            conf_reg    <= conf_next;
            last_reg    <= last_next;
            err_reg     <= err_next;
            cnt_reg     <= cnt_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
            bit_reg     <= bit_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_smp_reg <= hold_smp_next;
        out_reg      <= out_next;
        mr_reg       <= mr_next;
        mi_reg       <= mi_next;
        sr_reg       <= sr_next;
        si_reg       <= si_next;
        pr_reg       <= pr_next;
        q_reg        <= q_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        sr2_reg      <= sr2_next;
        si2_reg      <= si2_next;
        lt2_reg      <= lt2_next;
        ht2_reg      <= ht2_next;
        ar_reg       <= ar_next;
        ai_reg       <= ai_next;
        d_reg        <= d_next;
        kl_reg       <= kl_next;
        kh_reg       <= kh_next;
        ar2_reg      <= ar2_next;
        ai2_reg      <= ai2_next;
        pl_reg       <= pl_next;
        ph_reg       <= ph_next;
    end

`ifndef SYNTHESIS
    a_decide_then_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE) |=> (state_reg == ST_FINISH))
        else $error("decision not followed by result stage");

    a_skip_no_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_data.mode && skip_reg != '0)
        |=> (state_reg == ST_FINISH && !found_reg))
        else $error("skipped sample was checked or tagged");

    a_err_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (err_reg >= $past(err_reg)))
        else $error("repeat error count decreased");
`endif

endmodule

### rtl/pncd_cell.sv
// One window cell: holds one sample and one PN entry, passes them along the ring.
module pncd_cell import pncd_pkg::*; #(
    parameter int CELL_INDEX = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  smp_t      nb_smp,
    input  pnv_t      nb_pn,
    input  pnv_t      wr_pn,
    output smp_t      smp_q,
    output pnv_t      pn_q
);

    smp_t smp_reg, smp_next;
    pnv_t pn_reg, pn_next;
    logic pn_hit;

    assign pn_hit = ctl.pn_write && (32'(ctl.pn_index) == CELL_INDEX);

    always_comb begin
        smp_next = smp_reg;
        if (ctl.rotate || ctl.insert) begin
            smp_next = nb_smp;
        end
        pn_next = pn_reg;
        if (ctl.rotate) begin
            pn_next = nb_pn;
        end else if (pn_hit) begin
            pn_next = wr_pn;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smp_reg <= '0;
        end else begin
            smp_reg <= smp_next;
        end
    end

    always_ff @(posedge aclk) begin
        pn_reg <= pn_next;
    end

    assign smp_q = smp_reg;
    assign pn_q  = pn_reg;

endmodule

### rtl/pncd_smul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
module pncd_smul import pncd_pkg::*; #(
    parameter int XW = 48,
    parameter int YW = 40
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [XW-1:0]   x,
    input  logic [YW-1:0]   y,
    output logic            done,
    output logic [XW+YW-1:0] prod
);

    localparam int CNTW = $clog2(YW + 1);

    logic              busy_reg, busy_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic [XW+YW-1:0]  xs_reg, xs_next, acc_reg, acc_next;
    logic [YW-1:0]     ys_reg, ys_next;

    assign done = busy_reg && (cnt_reg == '0);

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        xs_next   = xs_reg;
        ys_next   = ys_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(YW);
            xs_next   = (XW+YW)'(x);
            ys_next   = y;
            acc_next  = '0;
        end else if (done) begin
            busy_next = 1'b0;
        end else if (busy_reg) begin
            if (ys_reg[0]) begin
                acc_next = acc_reg + xs_reg;
            end
            xs_next  = xs_reg << 1;
            ys_next  = ys_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        xs_reg  <= xs_next;
        ys_reg  <= ys_next;
        acc_reg <= acc_next;
    end

    assign prod = acc_reg;

endmodule
